// ----- hw/rtl/ffha_pkg.sv -----
package ffha_pkg;

  localparam int HOLES      = 64;
  localparam int SLOT_BITS  = $clog2(HOLES);
  localparam int LINK_BITS  = $clog2(HOLES + 1);
  localparam int CLICK_BITS = 24;

  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [LINK_BITS-1:0]  link_t;
  typedef logic [CLICK_BITS-1:0] click_t;
  typedef logic [CLICK_BITS:0]   wide_t;

  localparam link_t NIL_SLOT = link_t'(HOLES);

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  localparam logic CFG_INIT_BASE   = 1'b0;
  localparam logic CFG_INIT_LENGTH = 1'b1;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    slot_t  raddr;
    slot_t  waddr;
    logic   we_start;
    logic   we_size;
    logic   we_link;
    click_t wstart;
    click_t wsize;
    link_t  wlink;
    logic   clr;
  } tbl_req_t;

  typedef struct packed {
    logic [1:0] status;
    click_t     granted_base;
  } result_t;

endpackage

// ----- hw/rtl/ffha_alu.sv -----
module ffha_alu import ffha_pkg::*; (
  input  logic   op,
  input  click_t a,
  input  click_t b,
  output wide_t  res
);

  // res[CLICK_BITS] is the carry on add, the borrow on subtract
  assign res = (op == ALU_SUB) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});

endmodule

// ----- hw/rtl/ffha_table.sv -----
module ffha_table import ffha_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  tbl_req_t req,
  output click_t   rd_start,
  output click_t   rd_size,
  output link_t    rd_link
);

  click_t            start_mem [HOLES];
  click_t            size_mem  [HOLES];
  link_t             link_mem  [HOLES];
  logic [HOLES-1:0]  vld_r;

  always_ff @(posedge clk) begin
    if (req.we_start) begin
      start_mem[req.waddr] <= req.wstart;
    end
    if (req.we_size) begin
      size_mem[req.waddr] <= req.wsize;
    end
    if (req.we_link) begin
      link_mem[req.waddr] <= req.wlink;
    end
    rd_start <= start_mem[req.raddr];
    rd_size  <= size_mem[req.raddr];
    // unwritten link reads as the reset chain: slot i points at i+1
    rd_link  <= vld_r[req.raddr] ? link_mem[req.raddr]
                                 : link_t'(req.raddr) + link_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      vld_r <= '0;
    end else if (req.we_link) begin
      vld_r[req.waddr] <= 1'b1;
    end
  end

endmodule

// ----- hw/rtl/ffha_ctrl.sv -----
module ffha_ctrl import ffha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  click_t     block_base,
  input  click_t     size_clicks,
  input  click_t     init_base,
  input  click_t     init_length,
  output logic       res_valid,
  input  logic       res_ready,
  output result_t    res
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_A_CHK  = 4'd1;
  localparam logic [3:0] S_A_HIT  = 4'd2;
  localparam logic [3:0] S_A_UNL  = 4'd3;
  localparam logic [3:0] S_F_POP  = 4'd4;
  localparam logic [3:0] S_F_POP2 = 4'd5;
  localparam logic [3:0] S_F_WALK = 4'd6;
  localparam logic [3:0] S_F_P1   = 4'd7;
  localparam logic [3:0] S_F_P2   = 4'd8;
  localparam logic [3:0] S_F_S1   = 4'd9;
  localparam logic [3:0] S_F_S2   = 4'd10;
  localparam logic [3:0] S_F_W1   = 4'd11;
  localparam logic [3:0] S_F_W2   = 4'd12;
  localparam logic [3:0] S_F_W3   = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  logic [3:0] state_r, state_nxt;
  link_t      head_r, head_nxt;
  link_t      spare_r, spare_nxt;
  link_t      cur_r, cur_nxt;
  link_t      prev_r, prev_nxt;
  link_t      lk_r, lk_nxt;
  slot_t      n_r, n_nxt;
  click_t     base_r, base_nxt;
  click_t     size_r, size_nxt;
  click_t     pst_r, pst_nxt;
  click_t     psz_r, psz_nxt;
  click_t     cst_r, cst_nxt;
  click_t     csz_r, csz_nxt;
  click_t     mst_r, mst_nxt;
  click_t     msz_r, msz_nxt;
  click_t     diff_r, diff_nxt;
  logic       adj_r, adj_nxt;
  logic       pm_r, pm_nxt;
  logic       sm_r, sm_nxt;
  logic [1:0] status_r, status_nxt;
  click_t     granted_r, granted_nxt;

  tbl_req_t   treq;
  click_t     rd_start, rd_size;
  link_t      rd_link;
  logic       alu_op;
  click_t     alu_a, alu_b;
  wide_t      alu_res;

  ffha_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (treq),
    .rd_start (rd_start),
    .rd_size  (rd_size),
    .rd_link  (rd_link)
  );

  ffha_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_DONE);
  assign res.status = status_r;
  assign res.granted_base = granted_r;

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    spare_nxt   = spare_r;
    cur_nxt     = cur_r;
    prev_nxt    = prev_r;
    lk_nxt      = lk_r;
    n_nxt       = n_r;
    base_nxt    = base_r;
    size_nxt    = size_r;
    pst_nxt     = pst_r;
    psz_nxt     = psz_r;
    cst_nxt     = cst_r;
    csz_nxt     = csz_r;
    mst_nxt     = mst_r;
    msz_nxt     = msz_r;
    diff_nxt    = diff_r;
    adj_nxt     = adj_r;
    pm_nxt      = pm_r;
    sm_nxt      = sm_r;
    status_nxt  = status_r;
    granted_nxt = granted_r;
    alu_op      = ALU_ADD;
    alu_a       = '0;
    alu_b       = '0;
    treq        = '0;
    treq.raddr  = cur_r[SLOT_BITS-1:0];
    treq.waddr  = cur_r[SLOT_BITS-1:0];

    unique case (state_r)
      S_IDLE: begin
        treq.raddr = head_r[SLOT_BITS-1:0];
        if (in_valid) begin
          status_nxt  = ST_OK;
          granted_nxt = '0;
          base_nxt    = block_base;
          size_nxt    = size_clicks;
          prev_nxt    = NIL_SLOT;
          unique case (cmd)
            CMD_ALLOC: begin
              cur_nxt = head_r;
              if (head_r == NIL_SLOT) begin
                status_nxt = ST_NOMEM;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_A_CHK;
              end
            end
            CMD_FREE: begin
              if (size_clicks == '0) begin
                status_nxt = ST_ZERO;
                state_nxt  = S_DONE;
              end else if (spare_r == NIL_SLOT) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_F_POP;
              end
            end
            CMD_INIT: begin
              treq.clr  = 1'b1;
              head_nxt  = NIL_SLOT;
              spare_nxt = '0;
              base_nxt  = init_base;
              size_nxt  = init_length;
              state_nxt = (init_length == '0) ? S_DONE : S_F_POP;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_A_CHK: begin
        alu_op = ALU_SUB;
        alu_a  = rd_size;
        alu_b  = size_r;
        treq.raddr = rd_link[SLOT_BITS-1:0];
        if (!alu_res[CLICK_BITS]) begin
          granted_nxt = rd_start;
          mst_nxt     = rd_start;
          diff_nxt    = alu_res[CLICK_BITS-1:0];
          lk_nxt      = rd_link;
          state_nxt   = S_A_HIT;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = rd_link;
          if (rd_link == NIL_SLOT) begin
            status_nxt = ST_NOMEM;
            state_nxt  = S_DONE;
          end
        end
      end

      S_A_HIT: begin
        alu_a         = mst_r;
        alu_b         = size_r;
        treq.we_start = 1'b1;
        treq.we_size  = 1'b1;
        treq.wstart   = alu_res[CLICK_BITS-1:0];
        treq.wsize    = diff_r;
        state_nxt     = S_DONE;
        if (diff_r == '0) begin
          treq.we_link = 1'b1;
          treq.wlink   = spare_r;
          spare_nxt    = cur_r;
          if (prev_r == NIL_SLOT) begin
            head_nxt = lk_r;
          end else begin
            state_nxt = S_A_UNL;
          end
        end
      end

      S_A_UNL: begin
        treq.waddr   = prev_r[SLOT_BITS-1:0];
        treq.we_link = 1'b1;
        treq.wlink   = lk_r;
        state_nxt    = S_DONE;
      end

      S_F_POP: begin
        treq.raddr = spare_r[SLOT_BITS-1:0];
        n_nxt      = spare_r[SLOT_BITS-1:0];
        state_nxt  = S_F_POP2;
      end

      S_F_POP2: begin
        spare_nxt     = rd_link;
        treq.waddr    = n_r;
        treq.we_start = 1'b1;
        treq.we_size  = 1'b1;
        treq.wstart   = base_r;
        treq.wsize    = size_r;
        treq.raddr    = head_r[SLOT_BITS-1:0];
        cur_nxt       = head_r;
        state_nxt     = (head_r == NIL_SLOT) ? S_F_P1 : S_F_WALK;
      end

      S_F_WALK: begin
        alu_op = ALU_SUB;
        alu_a  = rd_start;
        alu_b  = base_r;
        treq.raddr = rd_link[SLOT_BITS-1:0];
        if (alu_res[CLICK_BITS]) begin
          prev_nxt = cur_r;
          pst_nxt  = rd_start;
          psz_nxt  = rd_size;
          cur_nxt  = rd_link;
          if (rd_link == NIL_SLOT) begin
            state_nxt = S_F_P1;
          end
        end else begin
          cst_nxt   = rd_start;
          csz_nxt   = rd_size;
          lk_nxt    = rd_link;
          state_nxt = S_F_P1;
        end
      end

      S_F_P1: begin
        alu_a = pst_r;
        alu_b = psz_r;
        if (prev_r == NIL_SLOT) begin
          pm_nxt    = 1'b0;
          mst_nxt   = base_r;
          msz_nxt   = size_r;
          state_nxt = S_F_S1;
        end else begin
          adj_nxt   = (alu_res == {1'b0, base_r});
          state_nxt = S_F_P2;
        end
      end

      S_F_P2: begin
        alu_a  = psz_r;
        alu_b  = size_r;
        pm_nxt = adj_r && !alu_res[CLICK_BITS];
        if (adj_r && !alu_res[CLICK_BITS]) begin
          mst_nxt = pst_r;
          msz_nxt = alu_res[CLICK_BITS-1:0];
        end else begin
          mst_nxt = base_r;
          msz_nxt = size_r;
        end
        state_nxt = S_F_S1;
      end

      S_F_S1: begin
        alu_a = mst_r;
        alu_b = msz_r;
        if (cur_r == NIL_SLOT) begin
          sm_nxt    = 1'b0;
          state_nxt = S_F_W1;
        end else begin
          adj_nxt   = (alu_res == {1'b0, cst_r});
          state_nxt = S_F_S2;
        end
      end

      S_F_S2: begin
        alu_a  = msz_r;
        alu_b  = csz_r;
        sm_nxt = adj_r && !alu_res[CLICK_BITS];
        if (adj_r && !alu_res[CLICK_BITS]) begin
          msz_nxt = alu_res[CLICK_BITS-1:0];
        end
        state_nxt = S_F_W1;
      end

      S_F_W1: begin
        treq.waddr   = pm_r ? prev_r[SLOT_BITS-1:0] : n_r;
        treq.we_size = 1'b1;
        treq.wsize   = msz_r;
        treq.we_link = 1'b1;
        treq.wlink   = sm_r ? lk_r : cur_r;
        state_nxt    = S_F_W2;
      end

      S_F_W2: begin
        if (pm_r) begin
          treq.waddr   = n_r;
          treq.we_link = 1'b1;
          treq.wlink   = spare_r;
          spare_nxt    = link_t'(n_r);
        end else if (prev_r == NIL_SLOT) begin
          head_nxt = link_t'(n_r);
        end else begin
          treq.waddr   = prev_r[SLOT_BITS-1:0];
          treq.we_link = 1'b1;
          treq.wlink   = link_t'(n_r);
        end
        state_nxt = sm_r ? S_F_W3 : S_DONE;
      end

      S_F_W3: begin
        treq.we_link = 1'b1;
        treq.wlink   = spare_r;
        spare_nxt    = cur_r;
        state_nxt    = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= NIL_SLOT;
      spare_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      spare_r <= spare_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    prev_r    <= prev_nxt;
    lk_r      <= lk_nxt;
    n_r       <= n_nxt;
    base_r    <= base_nxt;
    size_r    <= size_nxt;
    pst_r     <= pst_nxt;
    psz_r     <= psz_nxt;
    cst_r     <= cst_nxt;
    csz_r     <= csz_nxt;
    mst_r     <= mst_nxt;
    msz_r     <= msz_nxt;
    diff_r    <= diff_nxt;
    adj_r     <= adj_nxt;
    pm_r      <= pm_nxt;
    sm_r      <= sm_nxt;
    status_r  <= status_nxt;
    granted_r <= granted_nxt;
  end

endmodule

// ----- hw/rtl/first_fit_hole_allocator.sv -----
// Allocate and free walk the hole list one hole at a time between input transfer
// and out_tvalid. Throughput: one item at a time; in_tready rises as the result
// loads into the output register. A finished result may wait in the output register
// while the next item is processed.
// Reset: synchronous active-low; list empty, spare chain over all slots via per-slot
// link valid bits, config registers zero. No clearing pass.
module first_fit_hole_allocator import ffha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // cmd[1:0], block_base[25:2], size_clicks[49:26]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // status[1:0], granted_base[25:2]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  click_t  init_base_r, init_length_r;
  logic    res_valid, res_ready;
  result_t res;
  logic    out_valid_r;
  result_t out_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_base_r   <= '0;
      init_length_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_INIT_BASE:   init_base_r   <= cfg_data;
        CFG_INIT_LENGTH: init_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ffha_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .cmd         (in_tdata[1:0]),
    .block_base  (in_tdata[25:2]),
    .size_clicks (in_tdata[49:26]),
    .init_base   (init_base_r),
    .init_length (init_length_r),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_r.granted_base, out_r.status};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a second item while busy");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_tready)
    else $error("result raised while idle");

  a_base_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res.status != ST_OK) |-> (res.granted_base == '0))
    else $error("granted base set on a failed request");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_tvalid)
    else $error("result transfer lost");

endmodule
